[src/cfa_pkg.sv]
// Shared types and constants of the contiguous frame allocator.
`default_nettype none

package cfa_pkg;

  // Largest number of frames the allocator is built for by default.
  localparam int unsigned CfaMaxFrames = 64;

  localparam int unsigned CfgWidth    = 7;
  localparam int unsigned PidWidth    = 8;
  localparam int unsigned PageWidth   = 7;
  localparam int unsigned StartWidth  = 6;
  localparam int unsigned FreedWidth  = 7;

  // frames_in_use value after reset.
  localparam logic [CfgWidth-1:0] FramesInUseReset = 7'd64;

  // Largest count the frames_freed field can report.
  localparam logic [FreedWidth-1:0] FreedMax = 7'd127;

  // Register word index of frames_in_use on the configuration port.
  localparam logic RegFramesInUse = 1'b0;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [PidWidth-1:0]  process_id;
    logic [PageWidth-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic                  success;
    logic [StartWidth-1:0] start_frame;
    logic                  compacted;
    logic [FreedWidth-1:0] frames_freed;
  } rsp_t;

  typedef struct packed {
    logic                used;
    logic [PidWidth-1:0] owner;
  } frame_t;

  // Controls from the sequencer to the row of frame cells.
  typedef struct packed {
    logic rotate;  // whole row shifts down by one frame
    logic swap;    // odd-even exchange of free and used neighbors
    logic phase;   // which pair parity exchanges this cycle
  } ring_ctrl_t;

endpackage : cfa_pkg

`default_nettype wire

[src/cfa_frame_cell.sv]
// One frame of the allocator map: used bit and owner id.
`default_nettype none

module cfa_frame_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rotate_i,
  input  wire cfa_pkg::frame_t shift_i,
  input  wire logic            en_up_i,
  input  wire cfa_pkg::frame_t up_i,
  input  wire logic            en_dn_i,
  input  wire cfa_pkg::frame_t dn_i,
  output cfa_pkg::frame_t      q_o
);
  import cfa_pkg::*;

  logic                used_q, used_d;
  logic [PidWidth-1:0] owner_q, owner_d;

  // A free cell takes a used upper neighbor; a used cell above a free one
  // gives its place away. The two exchanges never meet in one cycle.
  always_comb begin
    used_d  = used_q;
    owner_d = owner_q;
    priority if (rotate_i) begin
      used_d  = shift_i.used;
      owner_d = shift_i.owner;
    end else if (en_up_i && !used_q && up_i.used) begin
      used_d  = 1'b1;
      owner_d = up_i.owner;
    end else if (en_dn_i && used_q && !dn_i.used) begin
      used_d  = 1'b0;
      owner_d = dn_i.owner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q <= owner_d;
  end

  assign q_o.used  = used_q;
  assign q_o.owner = owner_q;

endmodule : cfa_frame_cell

`default_nettype wire

[src/cfa_ctrl.sv]
// Command sequencer: scans the frame row at its head and writes frames back.
`default_nettype none

module cfa_ctrl #(
  parameter int unsigned MAX_FRAMES = cfa_pkg::CfaMaxFrames,
  parameter int unsigned IDX_W      = $clog2(MAX_FRAMES),
  parameter int unsigned CNT_W      = ($clog2(MAX_FRAMES + 1) > 7) ?
                                      $clog2(MAX_FRAMES + 1) : 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire cfa_pkg::req_t       req_i,
  input  wire logic [CNT_W-1:0]    n_i,
  input  wire cfa_pkg::frame_t     head_i,
  output cfa_pkg::frame_t          head_wb_o,
  output cfa_pkg::ring_ctrl_t      ctrl_o,
  output logic                     busy_o,
  output logic                     rsp_valid_o,
  output cfa_pkg::rsp_t            rsp_o
);
  import cfa_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StCompact,
    StMark,
    StFree
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [PidWidth-1:0] pid_q, pid_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  start_q, start_d;
  logic [CNT_W-1:0]  freed_q, freed_d;
  logic              fit_q, fit_d;
  logic              compacted_q, compacted_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic [CNT_W-1:0]  idx_c;
  logic              in_range;
  logic              last;

  assign idx_c    = CNT_W'(idx_q);
  assign in_range = idx_c < n_i;
  assign last     = idx_q == IDX_W'(MAX_FRAMES - 1);

  always_comb begin
    state_d     = state_q;
    idx_d       = last ? '0 : idx_q + IDX_W'(1);
    pid_d       = pid_q;
    count_d     = count_q;
    free_d      = free_q;
    run_d       = run_q;
    start_d     = start_q;
    freed_d     = freed_q;
    fit_d       = fit_q;
    compacted_d = compacted_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    head_wb_o   = head_i;

    unique case (state_q)
      StIdle: begin
        idx_d = '0;
        if (start_i) begin
          pid_d       = req_i.process_id;
          count_d     = CNT_W'(req_i.page_count);
          free_d      = '0;
          run_d       = '0;
          start_d     = '0;
          freed_d     = '0;
          fit_d       = 1'b0;
          compacted_d = 1'b0;
          if (req_i.command == CmdFree) begin
            state_d = StFree;
          end else if (req_i.page_count == '0) begin
            rsp_d       = '0;
            rsp_valid_d = 1'b1;
          end else begin
            state_d = StScan;
          end
        end
      end

      StScan: begin
        // Free count and first-fit search share one pass.
        if (in_range && !head_i.used) begin
          free_d = free_q + CNT_W'(1);
          run_d  = run_q + CNT_W'(1);
          if (!fit_q && run_q == '0) begin
            start_d = idx_c;
          end
          if (!fit_q && run_d == count_q) begin
            fit_d = 1'b1;
          end
        end else if (in_range) begin
          run_d = '0;
        end
        if (last) begin
          if (free_d < count_q) begin
            rsp_d       = '0;
            rsp_valid_d = 1'b1;
            state_d     = StIdle;
          end else if (fit_d) begin
            state_d = StMark;
          end else begin
            start_d     = n_i - free_d;
            compacted_d = 1'b1;
            state_d     = StCompact;
          end
        end
      end

      StCompact: begin
        if (last) begin
          state_d = StMark;
        end
      end

      StMark: begin
        if (idx_c >= start_q && idx_c < start_q + count_q) begin
          head_wb_o.used  = 1'b1;
          head_wb_o.owner = pid_q;
        end
        if (last) begin
          rsp_d.success      = 1'b1;
          rsp_d.start_frame  = start_q[StartWidth-1:0];
          rsp_d.compacted    = compacted_q;
          rsp_d.frames_freed = '0;
          rsp_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end

      StFree: begin
        if (in_range && head_i.used && head_i.owner == pid_q) begin
          head_wb_o.used = 1'b0;
          freed_d        = freed_q + CNT_W'(1);
        end
        if (last) begin
          rsp_d.success      = freed_d != '0;
          rsp_d.start_frame  = '0;
          rsp_d.compacted    = 1'b0;
          rsp_d.frames_freed = (freed_d > CNT_W'(FreedMax)) ?
                               FreedMax : freed_d[FreedWidth-1:0];
          rsp_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      pid_q       <= '0;
      count_q     <= '0;
      free_q      <= '0;
      run_q       <= '0;
      start_q     <= '0;
      freed_q     <= '0;
      fit_q       <= 1'b0;
      compacted_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pid_q       <= pid_d;
      count_q     <= count_d;
      free_q      <= free_d;
      run_q       <= run_d;
      start_q     <= start_d;
      freed_q     <= freed_d;
      fit_q       <= fit_d;
      compacted_q <= compacted_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign ctrl_o.rotate = (state_q == StScan) || (state_q == StMark) || (state_q == StFree);
  assign ctrl_o.swap   = state_q == StCompact;
  assign ctrl_o.phase  = idx_q[0];
  assign busy_o        = state_q != StIdle;
  assign rsp_valid_o   = rsp_valid_q;
  assign rsp_o         = rsp_q;

endmodule : cfa_ctrl

`default_nettype wire

[src/contiguous_frame_allocator.sv]
// Top level of the first-fit contiguous frame allocator with compaction.
// A free runs the free pass, a refused allocate the scan pass, a first-fit allocate scan
// and mark, a compacting allocate scan, compaction and mark; zero pages are answered from
// idle. One command is in work at a time; busy falls as the result shows, so the next word
// can be taken then. While it rotates the row passes one frame a cycle. Reset clears every
// used bit at once and sets frames_in_use to 64; results cannot stall.
`default_nettype none

module contiguous_frame_allocator #(
  parameter int unsigned MAX_FRAMES = cfa_pkg::CfaMaxFrames
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,

  // Command channel: a word is taken when start is high and busy is low.
  input  wire logic          start,
  output logic               busy,
  input  wire cfa_pkg::req_t req_i,

  // Result channel: one word per command, valid for exactly one cycle.
  output logic               result_valid_o,
  output cfa_pkg::rsp_t      rsp_o,

  // Configuration port, APB style. Word 0 holds frames_in_use.
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cfa_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_FRAMES);
  localparam int unsigned CntW = ($clog2(MAX_FRAMES + 1) > 7) ? $clog2(MAX_FRAMES + 1) : 7;

  // ---------------------------------------------------------------------------
  // Configuration register. The byte offset within a word is ignored; word 1
  // lies beyond the register list and reads as zero.
  // ---------------------------------------------------------------------------
  logic [CfgWidth-1:0] frames_in_use_q;
  logic                reg_sel;

  assign reg_sel = paddr[2] == RegFramesInUse;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - CfgWidth){1'b0}}, frames_in_use_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FramesInUseReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frames_in_use_q <= pwdata[CfgWidth-1:0];
    end
  end

  // Managed frame count, capped at the built size of the map.
  logic [CntW-1:0] n_frames;
  assign n_frames = (CntW'(frames_in_use_q) > CntW'(MAX_FRAMES)) ?
                    CntW'(MAX_FRAMES) : CntW'(frames_in_use_q);

  // ---------------------------------------------------------------------------
  // Sequencer. It sees frame 0 of the row at the head; while the row rotates,
  // the frames arrive there one after another in order of their index and the
  // sequencer feeds the (possibly rewritten) frame back in at the top. After
  // MAX_FRAMES shifts every frame is home again.
  // ---------------------------------------------------------------------------
  frame_t     cell_q [MAX_FRAMES];
  frame_t     head_wb;
  ring_ctrl_t ring_ctrl;

  cfa_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .IDX_W      (IdxW),
    .CNT_W      (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .n_i         (n_frames),
    .head_i      (cell_q[0]),
    .head_wb_o   (head_wb),
    .ctrl_o      (ring_ctrl),
    .busy_o      (busy),
    .rsp_valid_o (result_valid_o),
    .rsp_o       (rsp_o)
  );

  // ---------------------------------------------------------------------------
  // Compaction runs as an odd-even transposition over the managed frames:
  // in alternate cycles the even and the odd neighbor pairs exchange a free
  // lower frame with a used upper one. Used frames never pass each other, so
  // their order is kept, and the compaction pass settles every used frame at
  // the bottom. Pairs that reach past the managed count stay still.
  // ---------------------------------------------------------------------------
  logic [MAX_FRAMES-2:0] pair_en;

  for (genvar k = 0; k < MAX_FRAMES - 1; k++) begin : g_pair
    assign pair_en[k] = ring_ctrl.swap && (ring_ctrl.phase == ((k % 2) == 1)) &&
                        (CntW'(k + 1) < n_frames);
  end

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    frame_t shift_in;
    frame_t up_in;
    frame_t dn_in;
    logic   en_up;
    logic   en_dn;

    if (k < MAX_FRAMES - 1) begin : g_up
      assign shift_in = cell_q[k+1];
      assign up_in    = cell_q[k+1];
      assign en_up    = pair_en[k];
    end else begin : g_top
      assign shift_in = head_wb;
      assign up_in    = '0;
      assign en_up    = 1'b0;
    end

    if (k > 0) begin : g_dn
      assign dn_in = cell_q[k-1];
      assign en_dn = pair_en[k-1];
    end else begin : g_bottom
      assign dn_in = '0;
      assign en_dn = 1'b0;
    end

    cfa_frame_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .rotate_i (ring_ctrl.rotate),
      .shift_i  (shift_in),
      .en_up_i  (en_up),
      .up_i     (up_in),
      .en_dn_i  (en_dn),
      .dn_i     (dn_in),
      .q_o      (cell_q[k])
    );
  end

endmodule : contiguous_frame_allocator

`default_nettype wire

[dv/cfa_checker.sv]
// Checker of the frame allocator: predicts each result word and compares it.
module cfa_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          busy_i,
  input  wire cfa_pkg::req_t req_i,
  input  wire logic          result_valid_i,
  input  wire cfa_pkg::rsp_t rsp_i,
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic          pready_i,
  input  wire logic [2:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  // Own copy of the frame map and of the managed frame count.
  logic                frame_busy  [CfaMaxFrames];
  logic [PidWidth-1:0] frame_pid   [CfaMaxFrames];
  logic [CfgWidth-1:0] managed_cfg;

  rsp_t expected_rsps [$];

  // Applies one command to the frame map and returns the word it must produce.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    int unsigned n;
    int unsigned freed;
    int unsigned free_cnt;
    int unsigned run;
    int unsigned run_start;
    int unsigned base;
    int unsigned dst;
    bit          found;
    o = '0;
    n = (managed_cfg > CfaMaxFrames) ? CfaMaxFrames : managed_cfg;
    if (r.command == CmdFree) begin
      freed = 0;
      for (int i = 0; i < n; i++) begin
        if (frame_busy[i] && frame_pid[i] == r.process_id) begin
          frame_busy[i] = 1'b0;
          freed++;
        end
      end
      o.success = (freed > 0);
      o.frames_freed = (freed > FreedMax) ? FreedMax : FreedWidth'(freed);
      return o;
    end
    if (r.page_count == 0) return o;
    free_cnt = 0;
    for (int i = 0; i < n; i++) if (!frame_busy[i]) free_cnt++;
    if (free_cnt < r.page_count) return o;
    // Lowest run of free frames that is long enough.
    found = 1'b0;
    run = 0;
    run_start = 0;
    base = 0;
    for (int i = 0; i < n && !found; i++) begin
      if (!frame_busy[i]) begin
        if (run == 0) run_start = i;
        run++;
        if (run == r.page_count) begin
          found = 1'b1;
          base = run_start;
        end
      end else begin
        run = 0;
      end
    end
    // No run fits: slide the used frames down and place the run above them.
    if (!found) begin
      dst = 0;
      for (int i = 0; i < n; i++) begin
        if (frame_busy[i]) begin
          frame_pid[dst] = frame_pid[i];
          frame_busy[dst] = 1'b1;
          dst++;
        end
      end
      for (int i = dst; i < n; i++) frame_busy[i] = 1'b0;
      base = dst;
      o.compacted = 1'b1;
    end
    for (int i = 0; i < r.page_count && base + i < n; i++) begin
      frame_busy[base + i] = 1'b1;
      frame_pid[base + i] = r.process_id;
    end
    o.success = 1'b1;
    o.start_frame = StartWidth'(base);
    return o;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      managed_cfg = FramesInUseReset;
      for (int i = 0; i < CfaMaxFrames; i++) begin
        frame_busy[i] = 1'b0;
        frame_pid[i] = '0;
      end
      expected_rsps.delete();
      mismatches_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == RegFramesInUse) begin
        managed_cfg = pwdata_i[CfgWidth-1:0];
      end
      // The result of the previous word can leave at the edge that takes the next one.
      if (result_valid_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result word with none expected, actual %p", $time, rsp_i);
          mismatches_o++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("success", 8'(want.success), 8'(rsp_i.success));
          check_field("start_frame", 8'(want.start_frame), 8'(rsp_i.start_frame));
          check_field("compacted", 8'(want.compacted), 8'(rsp_i.compacted));
          check_field("frames_freed", 8'(want.frames_freed), 8'(rsp_i.frames_freed));
        end
      end
      if (start_i && !busy_i) expected_rsps.push_back(apply_request(req_i));
    end
    pending_o = expected_rsps.size();
  end

endmodule

[dv/tb_contiguous_frame_allocator.sv]
// Top of the frame allocator testbench: clock, reset, stimulus and verdict.
module tb_contiguous_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  // Owner ids that random words mostly draw from, so that frees find frames.
  // Together they set and clear every bit of the id.
  localparam logic [63:0] OwnerPool = 64'h00_01_5A_A5_FF_80_7F_33;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        req;
  logic        result_valid;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;

  // Managed frame count as last written, used to size the random requests.
  logic [CfgWidth-1:0] frames_cfg;

  contiguous_frame_allocator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .rsp_o          (rsp),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  cfa_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_valid_i (result_valid),
    .rsp_i          (rsp),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Most gaps are short, a few are long; in an eager stretch there are none.
  function automatic int unsigned pick_gap(bit eager);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (eager || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // A random command word. Page counts are mostly small against the managed
  // frame count so that the map fills, fragments and gets compacted; a few are
  // zero or larger than any map can hold.
  function automatic req_t random_request(logic [CfgWidth-1:0] cfg);
    req_t        r;
    int unsigned bound;
    int unsigned roll;
    bound = (cfg > CfaMaxFrames) ? CfaMaxFrames : cfg;
    if (bound == 0) bound = 1;
    r.command = ($urandom_range(0, 99) < 35) ? CmdFree : CmdAlloc;
    if ($urandom_range(0, 99) < 85) begin
      r.process_id = OwnerPool[8*$urandom_range(0, 7) +: 8];
    end else begin
      r.process_id = PidWidth'($urandom_range(0, 255));
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      r.page_count = PageWidth'($urandom_range(1, (bound > 4) ? bound / 4 : 1));
    end else if (roll < 90) begin
      r.page_count = PageWidth'($urandom_range(1, bound));
    end else if (roll < 95) begin
      r.page_count = '0;
    end else begin
      r.page_count = PageWidth'($urandom_range(65, 127));
    end
    return r;
  endfunction

  // Presents one command word from a falling edge on. busy only changes at a
  // rising edge, so a low busy seen here means the next rising edge takes the
  // word. With no gap, start stays high into the next word.
  task automatic issue(req_t r, int unsigned gap);
    while (busy) @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes frames_in_use through the configuration port while the block is idle.
  task automatic set_frames(logic [CfgWidth-1:0] value);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {RegFramesInUse, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    frames_cfg = value;
  endtask

  initial begin
    logic [CfgWidth-1:0] phase_cfg [7];
    bit                  eager;
    rst_n   = 1'b0;
    start   = 1'b0;
    req     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    frames_cfg = FramesInUseReset;
    phase_cfg = '{7'd64, 7'd12, 7'd1, 7'd37, 7'd127, 7'd2, 7'd64};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on the full map after reset.
    issue({CmdFree,  8'h05, 7'd0},   pick_gap(1'b0));  // free of an id that owns nothing
    issue({CmdAlloc, 8'h00, 7'd0},   pick_gap(1'b0));  // zero pages is refused
    issue({CmdAlloc, 8'h01, 7'd127}, pick_gap(1'b0));  // more than any map holds
    issue({CmdAlloc, 8'h01, 7'd65},  pick_gap(1'b0));
    issue({CmdAlloc, 8'h00, 7'd10},  pick_gap(1'b0));  // frames 0..9
    issue({CmdAlloc, 8'hFF, 7'd10},  pick_gap(1'b0));  // frames 10..19
    issue({CmdAlloc, 8'hAA, 7'd10},  pick_gap(1'b0));  // frames 20..29
    issue({CmdFree,  8'hFF, 7'd99},  pick_gap(1'b0));  // opens a hole of ten
    // 44 free frames but no run of 40: this one has to compact first.
    issue({CmdAlloc, 8'h55, 7'd40},  pick_gap(1'b0));
    issue({CmdAlloc, 8'h55, 7'd4},   pick_gap(1'b0));  // fills the map
    issue({CmdAlloc, 8'h07, 7'd1},   pick_gap(1'b0));  // full map refuses
    issue({CmdFree,  8'h55, 7'd1},   pick_gap(1'b0));
    issue({CmdFree,  8'h00, 7'd1},   pick_gap(1'b0));
    issue({CmdFree,  8'hAA, 7'd1},   pick_gap(1'b0));
    issue({CmdAlloc, 8'h80, 7'd64},  pick_gap(1'b0));  // whole map in one run
    issue({CmdFree,  8'h80, 7'd64},  pick_gap(1'b0));  // all 64 come back

    // No managed frames: nothing can be granted or freed.
    set_frames(7'd0);
    issue({CmdAlloc, 8'h01, 7'd1},   pick_gap(1'b0));
    issue({CmdFree,  8'h01, 7'd1},   pick_gap(1'b0));
    // A count above the built size is capped at the whole map.
    set_frames(7'd100);
    issue({CmdAlloc, 8'h03, 7'd64},  pick_gap(1'b0));
    // With one managed frame, the frames above keep their owner untouched.
    set_frames(7'd1);
    issue({CmdFree,  8'h03, 7'd0},   pick_gap(1'b0));
    issue({CmdAlloc, 8'h09, 7'd1},   pick_gap(1'b0));
    set_frames(7'd64);
    issue({CmdFree,  8'h03, 7'd0},   pick_gap(1'b0));
    issue({CmdFree,  8'h09, 7'd0},   pick_gap(1'b0));

    // Random part: several map sizes, each written while the block is idle.
    // Eager stretches without gaps alternate with idling ones, and now and
    // then the sender waits until every word has returned.
    eager = 1'b0;
    foreach (phase_cfg[p]) begin
      set_frames(phase_cfg[p]);
      for (int k = 0; k < 250; k++) begin
        if ($urandom_range(0, 39) == 0) eager = !eager;
        if ($urandom_range(0, 99) == 0) drain();
        issue(random_request(frames_cfg), pick_gap(eager));
      end
    end

    // Let the last words come back, then allow for the slowest command.
    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** contiguous_frame_allocator: PASSED **");
    end else begin
      $display("** contiguous_frame_allocator: FAILED **");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every word compacting and every gap long.
  initial begin
    #40ms;
    $display("** contiguous_frame_allocator: FAILED **");
    $finish;
  end

endmodule
